FILE: rtl/sha256_stream_hasher_defines.svh
// Assertion macros for the stream hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/sha_pkg.sv
package sha_pkg;
   typedef logic [31:0] word_type;

   localparam int unsigned WordCount = 8;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds = 64;

   typedef struct packed {
      logic       load_byte;
      logic [7:0] byte_value;
      logic       count_byte;
      logic       start_block;
      logic       round_step;
      logic       finish_block;
      logic       reset_message;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] byte_position;
      logic [6:0] round_number;
      logic [63:0] bit_length;
   } dp_status_type;

   localparam word_type InitHash [WordCount] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundConst [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(word_type v, int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction
endpackage

FILE: rtl/sha_if.sv
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;
   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha_datapath.sv
module sha_datapath
   import sha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [2:0]    read_index,
   output dp_status_type status,
   output word_type      hash_word
);
   word_type hash_ff [WordCount];
   word_type work_ff [WordCount];
   word_type sched_ff [BlockWords];
   logic [5:0]  pos_ff;
   logic [6:0]  round_ff;
   logic [63:0] len_ff;

   word_type t1, t2, w_new, w_cur;
   logic [3:0] widx;
   logic [4:0] shift;

   assign w_cur = sched_ff[0];
   assign w_new = (rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10))
      + sched_ff[9] + (rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3))
      + sched_ff[0];
   assign t1 = work_ff[7]
      + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25))
      + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
      + RoundConst[round_ff[5:0]] + w_cur;
   assign t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
      + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
   assign widx = pos_ff[5:2];
   assign shift = {3'(2'd3 - pos_ff[1:0]), 2'b00} << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         round_ff <= '0;
         len_ff <= '0;
         for (int i = 0; i < WordCount; i++) hash_ff[i] <= InitHash[i];
      end else begin
         if (cmd.load_byte) begin
            sched_ff[widx] <= (sched_ff[widx] & ~(32'hff << shift))
               | (32'(cmd.byte_value) << shift);
            pos_ff <= pos_ff + 6'd1;
         end
         if (cmd.count_byte) len_ff <= len_ff + 64'd8;
         if (cmd.start_block) begin
            for (int i = 0; i < WordCount; i++) work_ff[i] <= hash_ff[i];
            round_ff <= '0;
         end
         if (cmd.round_step) begin
            work_ff[7] <= work_ff[6];
            work_ff[6] <= work_ff[5];
            work_ff[5] <= work_ff[4];
            work_ff[4] <= work_ff[3] + t1;
            work_ff[3] <= work_ff[2];
            work_ff[2] <= work_ff[1];
            work_ff[1] <= work_ff[0];
            work_ff[0] <= t1 + t2;
            for (int i = 0; i < BlockWords - 1; i++) sched_ff[i] <= sched_ff[i + 1];
            sched_ff[BlockWords - 1] <= w_new;
            round_ff <= round_ff + 7'd1;
         end
         if (cmd.finish_block) begin
            for (int i = 0; i < WordCount; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
            round_ff <= '0;
         end
         if (cmd.reset_message) begin
            for (int i = 0; i < WordCount; i++) hash_ff[i] <= InitHash[i];
            len_ff <= '0;
            pos_ff <= '0;
         end
      end
   end

   assign status.byte_position = pos_ff;
   assign status.round_number = round_ff;
   assign status.bit_length = len_ff;
   assign hash_word = hash_ff[read_index];
endmodule

FILE: rtl/sha_control.sv
module sha_control
   import sha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sha_req_if.sink       req,
   sha_rsp_if.source     rsp,
   input  dp_status_type status,
   input  word_type      hash_word,
   output dp_cmd_type    cmd,
   output logic [2:0]    read_index
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRound = 3'd1;
   localparam logic [2:0] StFinish = 3'd2;
   localparam logic [2:0] StPad = 3'd3;
   localparam logic [2:0] StOut = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       closing_ff, closing_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] idx_ff, idx_in;
   word_type   word_ff, word_in;
   logic       pad_done_ff, pad_done_in;
   logic       pad_wrap_ff, pad_wrap_in;
   logic       accept, byte_fill, block_full, pad_fill;
   logic [7:0] pad_byte;
   logic [2:0] len_sel;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == StIdle);
   assign byte_fill = accept && req.byte_valid;
   assign block_full = (status.byte_position == 6'd63);
   assign len_sel = status.byte_position[2:0];
   assign pad_byte = (status.byte_position >= 6'd56 && !pad_wrap_ff)
      ? 8'(status.bit_length >> {3'd7 - len_sel, 3'b000}) : 8'h00;

   // When the end marker lands in the last eight bytes of a block, that block is
   // closed with zeros and the length goes into the next one.
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      closing_in = closing_ff;
      out_valid_in = out_valid_ff;
      idx_in = idx_ff;
      word_in = word_ff;
      pad_wrap_in = pad_wrap_ff;
      pad_fill = 1'b0;
      unique case (state_ff)
         StIdle: begin
            pad_wrap_in = 1'b0;
            if (accept) begin
               closing_in = req.last;
               idx_in = '0;
               if (req.byte_valid) begin
                  cmd.load_byte = 1'b1;
                  cmd.byte_value = req.data_byte;
                  cmd.count_byte = 1'b1;
                  if (block_full) begin
                     cmd.start_block = 1'b1;
                     state_in = StRound;
                  end else if (req.last) begin
                     state_in = StPad;
                  end
               end else if (req.last) begin
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            pad_fill = 1'b1;
            cmd.load_byte = 1'b1;
            cmd.byte_value = (idx_ff == 3'd0) ? 8'h80 : pad_byte;
            idx_in = 3'd1;
            if (status.byte_position == 6'd63) pad_wrap_in = 1'b0;
            else if (idx_ff == 3'd0 && status.byte_position >= 6'd56) pad_wrap_in = 1'b1;
            if (block_full) begin
               cmd.start_block = 1'b1;
               state_in = StRound;
            end
         end
         StRound: begin
            cmd.round_step = 1'b1;
            if (status.round_number == 7'(Rounds - 1)) state_in = StFinish;
         end
         StFinish: begin
            cmd.finish_block = 1'b1;
            if (!closing_ff) state_in = StIdle;
            else if (pad_done_ff) begin
               state_in = StOut;
               idx_in = '0;
            end else state_in = StPad;
         end
         StOut: begin
            if (!out_valid_ff || rsp.ready) begin
               if (out_valid_ff && idx_ff == 3'd7) begin
                  out_valid_in = 1'b0;
                  cmd.reset_message = 1'b1;
                  state_in = StIdle;
               end else begin
                  if (out_valid_ff) idx_in = idx_ff + 3'd1;
                  out_valid_in = 1'b1;
                  word_in = out_valid_ff ? hash_word : hash_word;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   assign pad_done_in = (state_ff == StIdle) ? 1'b0
      : (pad_fill && status.byte_position == 6'd63 && idx_ff == 3'd1 && !pad_wrap_ff)
         ? 1'b1 : pad_done_ff;

   assign read_index = (state_ff == StOut && out_valid_ff) ? idx_ff + 3'd1 : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         closing_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
         pad_done_ff <= 1'b0;
         pad_wrap_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         closing_ff <= closing_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= (state_ff == StOut && !out_valid_ff) ? 3'd0 : idx_in;
         pad_done_ff <= pad_done_in;
         pad_wrap_ff <= pad_wrap_in;
      end
      word_ff <= word_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.digest_word = word_ff;
   assign rsp.word_index = idx_ff;
   assign rsp.last_word = (idx_ff == 3'd7);
endmodule

FILE: rtl/sha256_stream_hasher.sv
// A byte that completes a block starts compression: the working registers are loaded,
// 64 rounds run and the hash is updated; no new byte is accepted until that is done.
// Closing a message pads byte by byte, then compresses one or two blocks and
// delivers eight words, one per cycle while the consumer is ready.
// Synchronous reset loads the initial hash value and clears length and position.
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher
   import sha_pkg::*;
(
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   dp_cmd_type    cmd;
   dp_status_type status;
   word_type      hash_word;
   logic [2:0]    read_index;

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .read_index(read_index),
      .status(status), .hash_word(hash_word));

   sha_control u_ctl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .status(status),
      .hash_word(hash_word), .cmd(cmd), .read_index(read_index));

   `SSH_ASSERT_IMPL(a_no_accept_busy, clock, reset, cmd.round_step, !req.ready)
   `SSH_ASSERT_NEXT(a_reset_clears, clock, reset, cmd.reset_message, status.byte_position == 6'd0)
   `SSH_ASSERT_IMPL(a_no_out_in_round, clock, reset, cmd.round_step, !rsp.valid)
endmodule
